// ===== sv/gsdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdf_pkg
// Request codes, register indexes and output constants shared by the
// grid signed distance field core.
// ----------------------------------------------------------------------------
package gsdf_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_MARK  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CELL_SIZE   = 2'd2;

    // Reset values of the registers.
    localparam logic [7:0]  GRID_WIDTH_RST  = 8'd128;
    localparam logic [7:0]  GRID_HEIGHT_RST = 8'd128;
    localparam logic [23:0] CELL_SIZE_RST   = 24'h010000;

    // Signed distance limits, 36 bits with 16 fraction bits.
    localparam logic [35:0] SD_MAX = 36'h7_FFFF_FFFF;
    localparam logic [35:0] SD_MIN = 36'h8_0000_0000;

    typedef logic [35:0] sdist_t;

endpackage

// ===== sv/grid_signed_distance_field_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_signed_distance_field_core
// Occupancy bitmap with city-block signed distance queries. The two raster
// transforms (outside and inside distance) run together over one memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid / in_stall  req_type, cell_x, cell_y
//  out       output     out_valid/out_stall  signed_distance, outside_grid,
//                                            unreached
//  cfg       input      APB write/read       grid_width, grid_height, cell_size
//
//  A mark or an unknown request leaves the sequencer idle for the next word;
//  a clean query goes through the memory read, the multiply and the output
//  register, and a query outside the grid skips the multiply. A query on a
//  stale field first runs the raster passes: S_FRD and S_FWR per active cell
//  forward and S_BRD0, S_BRD1 and S_BWR per cell backward, set by the single
//  distance memory port. A clear, and the pass after reset, sweep the whole
//  occupancy memory one entry a cycle; no word is accepted meanwhile.
//  A finished query waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module grid_signed_distance_field_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] cell_x,
    input  logic signed [15:0] cell_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [35:0] signed_distance,
    output logic               outside_grid,
    output logic               unreached
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 1);
    localparam int PW    = DW + 24;
    localparam logic [DW-1:0] SAT = DW'(MAX_WIDTH + MAX_HEIGHT);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_FRD  = 4'd2;
    localparam logic [3:0] S_FWR  = 4'd3;
    localparam logic [3:0] S_BRD0 = 4'd4;
    localparam logic [3:0] S_BRD1 = 4'd5;
    localparam logic [3:0] S_BWR  = 4'd6;
    localparam logic [3:0] S_QRD  = 4'd7;
    localparam logic [3:0] S_QMUL = 4'd8;
    localparam logic [3:0] S_QOUT = 4'd9;

    // One relaxation step: neighbor plus one, saturated, against the current.
    function automatic logic [DW-1:0] relax(input logic [DW-1:0] d,
                                            input logic [DW-1:0] nb);
        logic [DW:0] c;
        c = {1'b0, nb} + (DW+1)'(1);
        if (c > {1'b0, SAT})
        begin
            c = {1'b0, SAT};
        end
        relax = (c[DW-1:0] < d) ? c[DW-1:0] : d;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        cell_addr = AW'(32'(y) * MAX_WIDTH + 32'(x));
    endfunction

    logic [3:0]        state_reg;
    logic [7:0]        gw_reg;
    logic [7:0]        gh_reg;
    logic [23:0]       cs_reg;
    logic              stale_reg;
    logic [AW-1:0]     clr_reg;
    logic [XW-1:0]     x_reg;
    logic [YW-1:0]     y_reg;
    logic [2*DW-1:0]   nb_reg;
    logic [2*DW-1:0]   cur_reg;
    logic [AW-1:0]     qaddr_reg;
    logic              qin_reg;
    logic [PW-1:0]     prod_reg;
    logic              qocc_reg;
    logic              qunr_reg;
    logic              out_valid_reg;
    gsdf_pkg::sdist_t  sd_reg;
    logic              og_reg;
    logic              ur_reg;

    logic              cfg_wr;
    logic              in_acc;
    logic [CW-1:0]     act_w;
    logic [RW-1:0]     act_h;
    logic [XW-1:0]     wm1;
    logic [YW-1:0]     hm1;
    logic              req_inside;
    logic [AW-1:0]     cur_addr;
    logic              occ_we;
    logic [AW-1:0]     occ_waddr;
    logic              occ_wdata;
    logic [AW-1:0]     occ_raddr;
    logic              occ_rd;
    logic              dist_we;
    logic [2*DW-1:0]   dist_wdata;
    logic [AW-1:0]     dist_raddr;
    logic [2*DW-1:0]   dist_rd;
    logic [DW-1:0]     fwd_o;
    logic [DW-1:0]     fwd_i;
    logic [DW-1:0]     bwd_o;
    logic [DW-1:0]     bwd_i;
    logic [DW-1:0]     q_count;
    logic [PW+35:0]    prod_ext;
    logic [34:0]       mag;
    logic              out_free;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= gsdf_pkg::GRID_WIDTH_RST;
            gh_reg <= gsdf_pkg::GRID_HEIGHT_RST;
            cs_reg <= gsdf_pkg::CELL_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                gsdf_pkg::REG_GRID_WIDTH:  gw_reg <= pwdata[7:0];
                gsdf_pkg::REG_GRID_HEIGHT: gh_reg <= pwdata[7:0];
                gsdf_pkg::REG_CELL_SIZE:   cs_reg <= pwdata[23:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gsdf_pkg::REG_GRID_WIDTH:  prdata = {24'd0, gw_reg};
            gsdf_pkg::REG_GRID_HEIGHT: prdata = {24'd0, gh_reg};
            gsdf_pkg::REG_CELL_SIZE:   prdata = {8'd0, cs_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Active grid size, clamped to 1..MAX.
    always_comb
    begin
        if (gw_reg == 8'd0)
        begin
            act_w = CW'(1);
        end
        else if (32'(gw_reg) > MAX_WIDTH)
        begin
            act_w = CW'(MAX_WIDTH);
        end
        else
        begin
            act_w = CW'(gw_reg);
        end
        if (gh_reg == 8'd0)
        begin
            act_h = RW'(1);
        end
        else if (32'(gh_reg) > MAX_HEIGHT)
        begin
            act_h = RW'(MAX_HEIGHT);
        end
        else
        begin
            act_h = RW'(gh_reg);
        end
    end

    assign wm1 = XW'(act_w - CW'(1));
    assign hm1 = YW'(act_h - RW'(1));

    assign req_inside = !cell_x[15] && !cell_y[15] &&
                        ({1'b0, cell_x} < 17'(act_w)) &&
                        ({1'b0, cell_y} < 17'(act_h));

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cur_addr = cell_addr(x_reg, y_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // Memories: occupancy bit and the packed {outside, inside} distances.
    gsdf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rd)
    );

    gsdf_ram #(
        .WIDTH (2 * DW),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (cur_addr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rd)
    );

    // Occupancy write: a mark at accept, or the clearing sweep.
    always_comb
    begin
        occ_we    = 1'b0;
        occ_waddr = clr_reg;
        occ_wdata = 1'b0;
        if (state_reg == S_CLR)
        begin
            occ_we = 1'b1;
        end
        else if (in_acc && req_type == gsdf_pkg::REQ_MARK && req_inside)
        begin
            occ_we    = 1'b1;
            occ_waddr = AW'(32'(cell_y) * MAX_WIDTH + 32'(cell_x));
            occ_wdata = 1'b1;
        end
    end

    // Read address selection for both memories.
    always_comb
    begin
        occ_raddr  = cur_addr;
        dist_raddr = cur_addr;
        case (state_reg)
            S_FRD:   dist_raddr = AW'(32'(cur_addr) - MAX_WIDTH);
            S_BRD1:  dist_raddr = AW'(32'(cur_addr) + MAX_WIDTH);
            S_QRD:
            begin
                occ_raddr  = qaddr_reg;
                dist_raddr = qaddr_reg;
            end
            default: ;
        endcase
    end

    // Forward pass cell: seed from occupancy, relax with left and up.
    always_comb
    begin
        fwd_o = occ_rd ? '0 : SAT;
        fwd_i = occ_rd ? SAT : '0;
        if (x_reg != '0)
        begin
            fwd_o = relax(fwd_o, nb_reg[2*DW-1:DW]);
            fwd_i = relax(fwd_i, nb_reg[DW-1:0]);
        end
        if (y_reg != '0)
        begin
            fwd_o = relax(fwd_o, dist_rd[2*DW-1:DW]);
            fwd_i = relax(fwd_i, dist_rd[DW-1:0]);
        end
    end

    // Backward pass cell: relax with right and down.
    always_comb
    begin
        bwd_o = cur_reg[2*DW-1:DW];
        bwd_i = cur_reg[DW-1:0];
        if (x_reg != wm1)
        begin
            bwd_o = relax(bwd_o, nb_reg[2*DW-1:DW]);
            bwd_i = relax(bwd_i, nb_reg[DW-1:0]);
        end
        if (y_reg != hm1)
        begin
            bwd_o = relax(bwd_o, dist_rd[2*DW-1:DW]);
            bwd_i = relax(bwd_i, dist_rd[DW-1:0]);
        end
    end

    assign dist_we    = (state_reg == S_FWR) || (state_reg == S_BWR);
    assign dist_wdata = (state_reg == S_FWR) ? {fwd_o, fwd_i} : {bwd_o, bwd_i};

    // Query count select and magnitude saturation.
    assign q_count  = occ_rd ? dist_rd[DW-1:0] : dist_rd[2*DW-1:DW];
    assign prod_ext = {36'd0, prod_reg};
    assign mag      = (qunr_reg || (|prod_ext[PW+35:35])) ? gsdf_pkg::SD_MAX[34:0]
                                                          : prod_ext[34:0];

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            stale_reg     <= 1'b1;
            clr_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output register fills from the output state and empties on accept.
            if (state_reg == S_QOUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Any register write, an in-grid mark or a clear makes the field stale.
            if ((cfg_wr && paddr[3:2] <= gsdf_pkg::REG_CELL_SIZE) ||
                (in_acc && ((req_type == gsdf_pkg::REQ_MARK && req_inside) ||
                            req_type == gsdf_pkg::REQ_CLEAR)))
            begin
                stale_reg <= 1'b1;
            end
            else if (state_reg == S_BWR && x_reg == '0 && y_reg == '0)
            begin
                stale_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (req_type)
                            gsdf_pkg::REQ_CLEAR:
                            begin
                                clr_reg   <= '0;
                                state_reg <= S_CLR;
                            end
                            gsdf_pkg::REQ_QUERY:
                            begin
                                x_reg     <= '0;
                                y_reg     <= '0;
                                state_reg <= stale_reg ? S_FRD : S_QRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == DEPTH - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FWR;
                end
                S_FWR:
                begin
                    if (x_reg != wm1)
                    begin
                        x_reg     <= x_reg + XW'(1);
                        state_reg <= S_FRD;
                    end
                    else if (y_reg != hm1)
                    begin
                        x_reg     <= '0;
                        y_reg     <= y_reg + YW'(1);
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        state_reg <= S_BRD0;
                    end
                end
                S_BRD0:
                begin
                    state_reg <= S_BRD1;
                end
                S_BRD1:
                begin
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    if (x_reg != '0)
                    begin
                        x_reg     <= x_reg - XW'(1);
                        state_reg <= S_BRD0;
                    end
                    else if (y_reg != '0)
                    begin
                        x_reg     <= wm1;
                        y_reg     <= y_reg - YW'(1);
                        state_reg <= S_BRD0;
                    end
                    else
                    begin
                        state_reg <= S_QRD;
                    end
                end
                S_QRD:
                begin
                    state_reg <= qin_reg ? S_QMUL : S_QOUT;
                end
                S_QMUL:
                begin
                    state_reg <= S_QOUT;
                end
                S_QOUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            qin_reg   <= req_inside;
            qaddr_reg <= AW'(32'(cell_y) * MAX_WIDTH + 32'(cell_x));
        end
        if (state_reg == S_FWR)
        begin
            nb_reg <= {fwd_o, fwd_i};
        end
        if (state_reg == S_BWR)
        begin
            nb_reg <= {bwd_o, bwd_i};
        end
        if (state_reg == S_BRD1)
        begin
            cur_reg <= dist_rd;
        end
        if (state_reg == S_QMUL)
        begin
            prod_reg <= PW'(q_count) * PW'(cs_reg);
            qocc_reg <= occ_rd;
            qunr_reg <= (q_count >= SAT);
        end
        if (state_reg == S_QOUT && out_free)
        begin
            if (!qin_reg)
            begin
                sd_reg <= gsdf_pkg::SD_MIN;
                og_reg <= 1'b1;
                ur_reg <= 1'b0;
            end
            else
            begin
                sd_reg <= qocc_reg ? (36'd0 - {1'b0, mag}) : {1'b0, mag};
                og_reg <= 1'b0;
                ur_reg <= qunr_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign signed_distance = sd_reg;
    assign outside_grid    = og_reg;
    assign unreached       = ur_reg;

`ifndef SYNTHESIS
    // An outside query never reports an unreached cell and carries the floor.
    a_outside_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outside_grid) |-> (!unreached &&
            signed_distance == gsdf_pkg::SD_MIN))
        else $error("outside word malformed");

    // An unreached cell reports the saturated magnitude.
    a_unreached_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unreached) |-> (signed_distance == gsdf_pkg::SD_MAX ||
            signed_distance == (36'd0 - gsdf_pkg::SD_MAX)))
        else $error("unreached word not saturated");

    // A new word only appears after the output state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_QOUT))
        else $error("word produced outside output state");

    // The field stays stale for the whole duration of the raster passes.
    a_stale_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWR || state_reg == S_BRD0) |-> stale_reg)
        else $error("field not stale during recompute");
`endif

endmodule

// ===== sv/gsdf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gsdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== bench/grid_signed_distance_field_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_signed_distance_field_core_test
// Drives marks, clears and queries into the signed distance field core,
// rewrites the grid registers between phases, and compares every query
// word against a city-block distance predictor kept in the bench.
// ----------------------------------------------------------------------------
module grid_signed_distance_field_core_test;

    localparam int MW = 128;
    localparam int MH = 128;
    localparam int CELLS = MW * MH;
    localparam int DSAT = MW + MH;
    localparam int WATCH_LIMIT = 400000;

    typedef struct packed {
        logic signed [35:0] sdist;
        logic               outside;
        logic               unr;
    } sd_word_t;

    // Predictor of the distance field and queue of pending query answers.
    class sdf_scoreboard;
        bit          occ [CELLS];
        int unsigned dout [CELLS];
        int unsigned din [CELLS];
        int unsigned gw, gh, csize;
        bit          stale;
        sd_word_t    pending [$];
        int          errors;

        function new();
            gw = 128;
            gh = 128;
            csize = 65536;
            stale = 1;
            errors = 0;
            foreach (occ[i]) occ[i] = 0;
        endfunction

        function int unsigned act_w();
            return (gw < 1) ? 1 : ((gw > MW) ? MW : gw);
        endfunction

        function int unsigned act_h();
            return (gh < 1) ? 1 : ((gh > MH) ? MH : gh);
        endfunction

        function void set_reg(int idx, int unsigned val);
            if (idx == gsdf_pkg::REG_GRID_WIDTH) gw = val & 8'hFF;
            else if (idx == gsdf_pkg::REG_GRID_HEIGHT) gh = val & 8'hFF;
            else csize = val & 24'hFFFFFF;
            stale = 1;
        endfunction

        function int unsigned step_dist(int unsigned d, int unsigned nb);
            int unsigned c;
            c = nb + 1;
            if (c > DSAT) c = DSAT;
            return (c < d) ? c : d;
        endfunction

        // Two-pass city-block sweep seeded from cells of kind seed.
        function void sweep(ref int unsigned dm [CELLS], input bit seed,
                            input int w, input int h);
            int i;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    i = y * MW + x;
                    dm[i] = (occ[i] == seed) ? 0 : DSAT;
                end
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    i = y * MW + x;
                    if (x > 0) dm[i] = step_dist(dm[i], dm[i - 1]);
                    if (y > 0) dm[i] = step_dist(dm[i], dm[i - MW]);
                end
            for (int y = h - 1; y >= 0; y--)
                for (int x = w - 1; x >= 0; x--)
                begin
                    i = y * MW + x;
                    if (x + 1 < w) dm[i] = step_dist(dm[i], dm[i + 1]);
                    if (y + 1 < h) dm[i] = step_dist(dm[i], dm[i + MW]);
                end
        endfunction

        // Notes an accepted input word.
        function void note_word(logic [1:0] kind, int x, int y);
            int w, h, i;
            bit in_grid;
            longint unsigned mag;
            longint sd;
            int unsigned cnt;
            sd_word_t r;
            w = act_w();
            h = act_h();
            in_grid = x >= 0 && y >= 0 && x < w && y < h;
            if (kind == gsdf_pkg::REQ_MARK) begin
                if (in_grid) begin
                    occ[y * MW + x] = 1;
                    stale = 1;
                end
            end else if (kind == gsdf_pkg::REQ_CLEAR) begin
                foreach (occ[k]) occ[k] = 0;
                stale = 1;
            end else if (kind == gsdf_pkg::REQ_QUERY) begin
                if (stale) begin
                    sweep(dout, 1'b1, w, h);
                    sweep(din, 1'b0, w, h);
                    stale = 0;
                end
                if (!in_grid) begin
                    r.sdist = gsdf_pkg::SD_MIN;
                    r.outside = 1;
                    r.unr = 0;
                end else begin
                    i = y * MW + x;
                    cnt = occ[i] ? din[i] : dout[i];
                    r.unr = cnt >= DSAT;
                    if (r.unr) mag = gsdf_pkg::SD_MAX;
                    else begin
                        mag = longint'(cnt) * longint'(csize);
                        if (mag > gsdf_pkg::SD_MAX) mag = gsdf_pkg::SD_MAX;
                    end
                    sd = occ[i] ? -longint'(mag) : longint'(mag);
                    r.sdist = sd[35:0];
                    r.outside = 0;
                end
                pending.push_back(r);
            end
        endfunction

        // Checks one accepted result word against the oldest expectation.
        function void check_word(sd_word_t got);
            sd_word_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word, distance %0d", got.sdist);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.sdist !== e.sdist) begin
                $error("signed_distance expected %0d actual %0d", e.sdist, got.sdist);
                errors++;
            end
            if (got.outside !== e.outside) begin
                $error("outside_grid expected %0b actual %0b", e.outside, got.outside);
                errors++;
            end
            if (got.unr !== e.unr) begin
                $error("unreached expected %0b actual %0b", e.unr, got.unr);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [35:0] signed_distance;
    logic               outside_grid;
    logic               unreached;

    sdf_scoreboard sb;
    bit            calm;
    int            idle_cycles;

    grid_signed_distance_field_core #(
        .MAX_WIDTH  (MW),
        .MAX_HEIGHT (MH)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .cell_x          (cell_x),
        .cell_y          (cell_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .signed_distance (signed_distance),
        .outside_grid    (outside_grid),
        .unreached       (unreached)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall, check every accepted word.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_word(sd_word_t'{signed_distance, outside_grid, unreached});
            out_stall <= (!calm && $urandom_range(99) < 9);
        end
    end

    // Watchdog on cycles with no accepted word at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_LIMIT) begin
            $display("status: fail");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.set_reg(idx, val);
    endtask

    // Sends one word, with an optional random gap first.
    task automatic send_word(logic [1:0] kind, int x, int y);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        req_type <= kind;
        cell_x   <= x[15:0];
        cell_y   <= y[15:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(kind, $signed(x[15:0]), $signed(y[15:0]));
    endtask

    // Drops valid and waits until every query answer is in and the core is quiet.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (CELLS + 100) @(posedge clk);
    endtask

    // Random coordinate: mostly in the grid, sometimes anywhere.
    function automatic int pick_coord(int unsigned lim);
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(lim - 1);
        if (r < 90) return lim;
        if (r < 95) return -1 - $urandom_range(3);
        return $signed(16'($urandom));
    endfunction

    task automatic random_phase(int n, int mark_pct);
        int unsigned r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < mark_pct)
                send_word(gsdf_pkg::REQ_MARK, pick_coord(sb.act_w()),
                          pick_coord(sb.act_h()));
            else if (r < 97)
                send_word(gsdf_pkg::REQ_QUERY, pick_coord(sb.act_w()),
                          pick_coord(sb.act_h()));
            else if (r < 98)
                send_word(gsdf_pkg::REQ_RSVD, $urandom, $urandom);
            else
                send_word(gsdf_pkg::REQ_CLEAR, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int ws [6] = '{1, 128, 7, 200, 0, 20};
        int hs [6] = '{1, 128, 5, 3, 255, 16};
        sb = new();
        calm = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        req_type = gsdf_pkg::REQ_MARK;
        cell_x = 0;
        cell_y = 0;
        out_stall = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (CELLS + 20) @(posedge clk);

        // Directed part: empty map, edges, extremes, unknown kind, clear.
        reg_write(gsdf_pkg::REG_GRID_WIDTH, 16);
        reg_write(gsdf_pkg::REG_GRID_HEIGHT, 12);
        send_word(gsdf_pkg::REQ_QUERY, 0, 0);
        send_word(gsdf_pkg::REQ_MARK, 0, 0);
        send_word(gsdf_pkg::REQ_MARK, 15, 11);
        send_word(gsdf_pkg::REQ_MARK, 16'sh7FFF, -32768);
        send_word(gsdf_pkg::REQ_MARK, -32768, 16'sh7FFF);
        send_word(gsdf_pkg::REQ_QUERY, 0, 0);
        send_word(gsdf_pkg::REQ_QUERY, 7, 6);
        send_word(gsdf_pkg::REQ_QUERY, 15, 11);
        send_word(gsdf_pkg::REQ_QUERY, 16, 0);
        send_word(gsdf_pkg::REQ_QUERY, -1, 0);
        send_word(gsdf_pkg::REQ_QUERY, 16'sh7FFF, -32768);
        send_word(gsdf_pkg::REQ_RSVD, 3, 3);
        send_word(gsdf_pkg::REQ_QUERY, 3, 3);
        drain();
        reg_write(gsdf_pkg::REG_CELL_SIZE, 24'hFFFFFF);
        send_word(gsdf_pkg::REQ_QUERY, 8, 6);
        send_word(gsdf_pkg::REQ_QUERY, 0, 0);
        drain();
        reg_write(gsdf_pkg::REG_CELL_SIZE, 0);
        send_word(gsdf_pkg::REQ_QUERY, 8, 6);
        send_word(gsdf_pkg::REQ_CLEAR, 0, 0);
        send_word(gsdf_pkg::REQ_QUERY, 1, 1);
        send_word(gsdf_pkg::REQ_MARK, -1, -1);
        send_word(gsdf_pkg::REQ_QUERY, 2, 2);
        drain();
        reg_write(gsdf_pkg::REG_CELL_SIZE, 1);

        // Random phases over several grid settings.
        for (int p = 0; p < 6; p++)
        begin
            reg_write(gsdf_pkg::REG_GRID_WIDTH, ws[p]);
            reg_write(gsdf_pkg::REG_GRID_HEIGHT, hs[p]);
            reg_write(gsdf_pkg::REG_CELL_SIZE, (p % 2) ? $urandom_range(24'hFFFFFF) :
                      $urandom_range(24'h20000, 1));
            calm = (p == 2);
            random_phase(315, (p == 4) ? 3 : 25);
            drain();
        end
        calm = 0;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gsdf_pkg.sv
sv/gsdf_ram.sv
sv/grid_signed_distance_field_core.sv
bench/grid_signed_distance_field_core_test.sv
